// ----- hdl/decimal_argument_summer_macros.svh -----
// Assertion macros for the decimal argument summer.
`ifndef DECIMAL_ARGUMENT_SUMMER_MACROS_SVH
`define DECIMAL_ARGUMENT_SUMMER_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define DAS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define DAS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define DAS_ASSERT(name, prop, msg)
`define DAS_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ----- hdl/dasum_pkg.sv -----
// Types, codes and constants shared by the decimal argument summer.
`default_nettype none
package dasum_pkg;

    localparam int SUM_WIDTH     = 32;
    localparam int MAG_WIDTH     = SUM_WIDTH + 1;  // holds 2^(SUM_WIDTH-1)
    localparam int NDIG          = 10;             // decimal digits of 2^31
    localparam int IDX_WIDTH     = 4;
    localparam int BIT_CNT_WIDTH = 5;

    // input commands
    localparam logic [1:0] CMD_CHAR     = 2'd0;
    localparam logic [1:0] CMD_END_ARG  = 2'd1;
    localparam logic [1:0] CMD_END_LIST = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_ARGS   = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    // characters
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
    } t_in;

    typedef struct packed {
        logic [1:0]                  status;
        logic signed [SUM_WIDTH-1:0] total;
        logic [7:0]                  out_char;
        logic                        last;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_LEAD,
        S_SIGN,
        S_DIGIT,
        S_NL,
        S_ERR
    } t_state;

    typedef enum logic [1:0] {
        EM_SIGN,
        EM_DIGIT,
        EM_NEWLINE,
        EM_FAIL
    } t_emit;

    typedef struct packed {
        logic  take_in;    // input transaction accepted
        logic  conv_step;  // one binary-to-BCD shift
        logic  set_idx;    // point at the leading digit
        logic  emit;       // load the output register
        t_emit kind;
        logic  idx_dec;    // move to the next lower digit
    } t_dp_cmd;

    typedef struct packed {
        logic fail_now;    // end of list right now would report a failure
        logic conv_last;   // final conversion step
        logic neg;         // sum being printed is negative
        logic out_free;    // output register can take a result this cycle
        logic idx_zero;    // current digit is the units digit
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- hdl/dasum_dp.sv -----
// Datapath: argument parsing, running sum, BCD conversion and output register.
`default_nettype none
`include "decimal_argument_summer_macros.svh"
module dasum_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dasum_pkg::t_dp_cmd i_cmd,
    input  wire dasum_pkg::t_in    i_in,
    input  wire logic              i_stall,
    output dasum_pkg::t_dp_sts     o_sts,
    output logic                   o_valid,
    output dasum_pkg::t_out        o_data
);
    import dasum_pkg::*;

    localparam int MX_WIDTH = MAG_WIDTH + 4;
    localparam int EX_WIDTH = SUM_WIDTH + 2;
    localparam logic [MX_WIDTH-1:0]  LIM_X   = MX_WIDTH'(1) << (SUM_WIDTH - 1);
    localparam logic [MAG_WIDTH-1:0] LIM_M   = MAG_WIDTH'(1) << (SUM_WIDTH - 1);
    localparam logic [MAG_WIDTH-1:0] MAX_M   = LIM_M - MAG_WIDTH'(1);

    // argument and sum state
    logic [1:0]                  r_err;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic                        r_any;
    logic [MAG_WIDTH-1:0]        r_mag;
    logic                        r_mag_over, r_neg_sign, r_seen_char;
    logic                        r_seen_digit, r_bad_char;

    // end-of-list and emission state
    logic [1:0]                  r_fin_status;
    logic signed [SUM_WIDTH-1:0] r_total;
    logic                        r_res_neg;
    logic [SUM_WIDTH-1:0]        r_bin;
    logic [3:0]                  r_bcd [NDIG];
    logic [BIT_CNT_WIDTH-1:0]    r_bit_cnt;
    logic [IDX_WIDTH-1:0]        r_idx;
    logic                        r_out_valid;
    t_out                        r_out;

    // character decode
    logic                 is_sign, is_digit;
    logic [MX_WIDTH-1:0]  mag_x10;
    logic                 mag_ovf;

    always_comb begin
        is_sign  = !r_seen_char && (i_in.ch == CH_MINUS || i_in.ch == CH_PLUS);
        is_digit = (i_in.ch >= CH_ZERO) && (i_in.ch <= CH_NINE);
        mag_x10  = (MX_WIDTH'(r_mag) << 3) + (MX_WIDTH'(r_mag) << 1)
                 + MX_WIDTH'(i_in.ch[3:0]);
        mag_ovf  = mag_x10 > LIM_X;
    end

    // end of argument
    logic                       arg_bad, arg_range, sum_fits;
    logic signed [EX_WIDTH-1:0] sum_ext, mag_ext, sum_new;

    always_comb begin
        arg_bad   = !r_seen_digit || r_bad_char;
        arg_range = r_mag_over || (!r_neg_sign && r_mag > MAX_M);
        sum_ext   = EX_WIDTH'(r_sum);
        mag_ext   = signed'(EX_WIDTH'(r_mag));
        sum_new   = r_neg_sign ? (sum_ext - mag_ext) : (sum_ext + mag_ext);
        sum_fits  = (sum_new[EX_WIDTH-1] == sum_new[EX_WIDTH-2])
                 && (sum_new[EX_WIDTH-2] == sum_new[SUM_WIDTH-1]);
    end

    // status the list would end with now
    logic [1:0]           fail_code;
    logic [SUM_WIDTH-1:0] sum_u, sum_abs;

    always_comb begin
        if (r_err != ST_OK) begin
            fail_code = r_err;
        end else if (!r_any) begin
            fail_code = ST_NO_ARGS;
        end else begin
            fail_code = ST_OK;
        end
        sum_u   = r_sum;
        sum_abs = r_sum[SUM_WIDTH-1] ? (~sum_u + 1'b1) : sum_u;
    end

    // double-dabble step and leading-digit search
    logic [3:0]           adj      [NDIG];
    logic [3:0]           bcd_next [NDIG];
    logic [IDX_WIDTH-1:0] top_idx;

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? (r_bcd[i] + 4'd3) : r_bcd[i];
        end
        bcd_next[0] = {adj[0][2:0], r_bin[SUM_WIDTH-1]};
        for (int i = 1; i < NDIG; i++) begin
            bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
        end
        top_idx = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i] != 4'd0) begin
                top_idx = IDX_WIDTH'(i);
            end
        end
    end

    logic in_char, in_end_arg, in_end_list;
    assign in_char     = i_cmd.take_in && (i_in.cmd == CMD_CHAR) && (r_err == ST_OK);
    assign in_end_arg  = i_cmd.take_in && (i_in.cmd == CMD_END_ARG) && (r_err == ST_OK);
    assign in_end_list = i_cmd.take_in && (i_in.cmd == CMD_END_LIST);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err        <= ST_OK;
            r_sum        <= '0;
            r_any        <= 1'b0;
            r_mag        <= '0;
            r_mag_over   <= 1'b0;
            r_neg_sign   <= 1'b0;
            r_seen_char  <= 1'b0;
            r_seen_digit <= 1'b0;
            r_bad_char   <= 1'b0;
            r_bit_cnt    <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_char) begin
                r_seen_char <= 1'b1;
                if (is_sign) begin
                    r_neg_sign <= (i_in.ch == CH_MINUS);
                end else if (is_digit) begin
                    r_seen_digit <= 1'b1;
                    if (!r_mag_over) begin
                        if (mag_ovf) begin
                            r_mag_over <= 1'b1;
                            r_mag      <= LIM_M;
                        end else begin
                            r_mag <= mag_x10[MAG_WIDTH-1:0];
                        end
                    end
                end else begin
                    r_bad_char <= 1'b1;
                end
            end
            if (in_end_arg) begin
                r_any <= 1'b1;
                if (arg_bad) begin
                    r_err <= ST_MALFORMED;
                end else if (arg_range || !sum_fits) begin
                    r_err <= ST_RANGE;
                end else begin
                    r_sum <= sum_new[SUM_WIDTH-1:0];
                end
            end
            if (in_end_arg || in_end_list) begin
                r_mag        <= '0;
                r_mag_over   <= 1'b0;
                r_neg_sign   <= 1'b0;
                r_seen_char  <= 1'b0;
                r_seen_digit <= 1'b0;
                r_bad_char   <= 1'b0;
            end
            if (in_end_list) begin
                r_err     <= ST_OK;
                r_sum     <= '0;
                r_any     <= 1'b0;
                r_bit_cnt <= '0;
            end
            if (i_cmd.conv_step) begin
                r_bit_cnt <= r_bit_cnt + 1'b1;
            end
            if (i_cmd.set_idx) begin
                r_idx <= top_idx;
            end else if (i_cmd.idx_dec) begin
                r_idx <= r_idx - 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_end_list) begin
            r_fin_status <= fail_code;
            r_total      <= r_sum;
            r_res_neg    <= r_sum[SUM_WIDTH-1];
            r_bin        <= sum_abs;
            for (int i = 0; i < NDIG; i++) begin
                r_bcd[i] <= 4'd0;
            end
        end else if (i_cmd.conv_step) begin
            r_bin <= r_bin << 1;
            for (int i = 0; i < NDIG; i++) begin
                r_bcd[i] <= bcd_next[i];
            end
        end
        if (i_cmd.emit) begin
            case (i_cmd.kind)
                EM_SIGN: begin
                    r_out <= '{status: ST_OK, total: r_total, out_char: CH_MINUS, last: 1'b0};
                end
                EM_DIGIT: begin
                    r_out <= '{status: ST_OK, total: r_total,
                               out_char: {CH_DIGIT_HI, r_bcd[r_idx]}, last: 1'b0};
                end
                EM_NEWLINE: begin
                    r_out <= '{status: ST_OK, total: r_total, out_char: CH_NEWLINE,
                               last: 1'b1};
                end
                default: begin
                    r_out <= '{status: r_fin_status, total: '0, out_char: 8'd0,
                               last: 1'b1};
                end
            endcase
        end
    end

    always_comb begin
        o_sts.fail_now  = (fail_code != ST_OK);
        o_sts.conv_last = (r_bit_cnt == BIT_CNT_WIDTH'(SUM_WIDTH - 1));
        o_sts.neg       = r_res_neg;
        o_sts.out_free  = !r_out_valid || !i_stall;
        o_sts.idx_zero  = (r_idx == '0);
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `DAS_ASSERT(a_fail_is_last, r_out_valid && r_out.status != ST_OK |-> r_out.last && r_out.out_char == 8'd0, "failure result must be a lone last result")
    `DAS_ASSERT(a_idx_in_range, r_idx < IDX_WIDTH'(NDIG), "digit index beyond the digit store")

endmodule
`default_nettype wire

// ----- hdl/dasum_ctrl.sv -----
// Controller: input acceptance and sequencing of the end-of-list results.
`default_nettype none
`include "decimal_argument_summer_macros.svh"
module dasum_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [1:0]         i_cmd,
    input  wire dasum_pkg::t_dp_sts i_sts,
    output logic                    o_stall,
    output dasum_pkg::t_dp_cmd      o_cmd
);
    import dasum_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_cmd == CMD_END_LIST) begin
                    n_state = i_sts.fail_now ? S_ERR : S_CONV;
                end
            end
            S_CONV: begin
                if (i_sts.conv_last) n_state = S_LEAD;
            end
            S_LEAD: begin
                n_state = i_sts.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (i_sts.out_free) n_state = S_DIGIT;
            end
            S_DIGIT: begin
                if (i_sts.out_free && i_sts.idx_zero) n_state = S_NL;
            end
            S_NL, S_ERR: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall         = (r_state != S_IDLE);
        o_cmd.take_in   = i_valid && (r_state == S_IDLE);
        o_cmd.conv_step = (r_state == S_CONV);
        o_cmd.set_idx   = (r_state == S_LEAD);
        o_cmd.emit      = 1'b0;
        o_cmd.kind      = EM_FAIL;
        o_cmd.idx_dec   = 1'b0;
        case (r_state)
            S_SIGN: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.kind = EM_SIGN;
            end
            S_DIGIT: begin
                o_cmd.emit    = i_sts.out_free;
                o_cmd.kind    = EM_DIGIT;
                o_cmd.idx_dec = i_sts.out_free && !i_sts.idx_zero;
            end
            S_NL: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.kind = EM_NEWLINE;
            end
            S_ERR: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.kind = EM_FAIL;
            end
            default: begin
                o_cmd.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `DAS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> r_state == S_IDLE, "reset must return to idle")
    `DAS_ASSERT(a_list_starts_run, r_state == S_IDLE && i_valid && i_cmd == CMD_END_LIST |=> r_state != S_IDLE, "end of list did not start a result run")
    `DAS_ASSERT(a_units_then_nl, r_state == S_DIGIT && i_sts.out_free && i_sts.idx_zero |=> r_state == S_NL, "units digit not followed by newline")

endmodule
`default_nettype wire

// ----- hdl/decimal_argument_summer.sv -----
// Top level of the decimal argument summer.
`default_nettype none
// Sums signed decimal arguments given as ASCII characters and prints the
// result. Each input transaction is a character, an end-of-argument mark or
// an end-of-list mark. Characters and end-of-argument marks are taken one per
// clock while the input is not stalled; each updates a saturating digit
// magnitude register or the 32-bit running sum. An end-of-list mark stalls
// the input until its last result has been loaded into the output register.
// On failure that is one status transaction, loaded from the error state as
// soon as the output register is free. On success the magnitude of the sum
// goes through a bit-serial binary-to-BCD converter (one bit per cycle), a
// lead state picks the leading digit, and then one result per cycle follows
// while the receiver does not stall: an optional '-', the digits from most
// significant down, and a newline marked last, at most 12 results in all.
// Status codes: 0 ok, 1 no arguments, 2 malformed argument, 3 range
// overflow. After a failure further characters and marks are ignored until
// the end of the list, and every end of list returns the argument and sum
// state to its reset values.
module decimal_argument_summer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire dasum_pkg::t_in i_data,
    output logic                o_stall,
    output logic                o_valid,
    output dasum_pkg::t_out     o_data,
    input  wire logic           i_stall
);
    import dasum_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    dasum_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_data.cmd),
        .i_sts   (dp_sts),
        .o_stall (o_stall),
        .o_cmd   (dp_cmd)
    );

    dasum_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_in    (i_data),
        .i_stall (i_stall),
        .o_sts   (dp_sts),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire
